@@ rtl/ellipsoid_grid_cell_area_defines.svh @@
// assertion macros for the ellipsoid grid cell area block
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef ELLIPSOID_GRID_CELL_AREA_DEFINES_SVH
`define ELLIPSOID_GRID_CELL_AREA_DEFINES_SVH

// same-cycle implication, held off during reset
`define EGCA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define EGCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/egca_pkg.sv @@
// shared constants for the ellipsoid grid cell area block
// no dependencies
`default_nettype none

package egca_pkg;

    // q30 fixed point one
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    // pi in q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    // first eccentricity squared of wgs84 in q30
    localparam logic [63:0] E2_Q30 = 64'd7188036;
    // (pi/180)^2 * b^2 / 1e6 in q16, km^2 per square degree at the equator scale
    localparam logic [63:0] K_Q16 = 64'd806687348;
    // number of taylor terms in the cosine
    localparam int unsigned TAYLOR_TERMS = 8;

    // register map
    localparam logic REG_CELL_SIZE = 1'b0;
    localparam logic [15:0] CELL_SIZE_RESET = 16'd256;

endpackage

`default_nettype wire

@@ rtl/ellipsoid_grid_cell_area.sv @@
// top level of the ellipsoid grid cell area block
// depends on egca_pkg, egca_div_cell, egca_horner_cell and the defines header
//
// usage: latitudes enter on the s_axis channel (tdata[17:0], two's complement,
// LAT_FRAC_BITS fractional bits) and one area per latitude leaves on m_axis
// (tdata[39:0], km^2 with 8 fractional bits), in order. The cell edge is set
// through the apb port, register 0 at address 0 (degrees, 8 fractional bits);
// write it only while no transaction is in flight.
// throughput: one transaction per cycle while the receiver does not stall.
// pipeline, the same for any LAT_FRAC_BITS: 31 cells of the bit-per-cycle
// cos / w^2 division chain, eight three-stage horner cells and twelve single
// stages (magnitude, angle product, three for the reciprocal division by 180,
// x squared, three for sin^2 and w^2, scale, cell size, output register).
// when the receiver stalls, the pipeline keeps running until the output register
// and the skid register are both full, then s_axis tready drops.
// reset clears all valid bits and sets the cell edge to one degree.
`default_nettype none

`include "ellipsoid_grid_cell_area_defines.svh"

module ellipsoid_grid_cell_area #(
    parameter int unsigned LAT_FRAC_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // latitude stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // [17:0] latitude
    // area stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [39:0] cell_area
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned PROD1_W = 50;
    localparam int unsigned DIV1_W  = PROD1_W - LAT_FRAC_BITS;
    localparam int unsigned LO_W    = 22;
    localparam int unsigned HI_W    = DIV1_W - LO_W;
    // ceil(2^38 / 180): exact quotient by 180 for any dividend below 2^30
    localparam logic [63:0] RECIP_180 = 64'd1527099484;
    localparam int unsigned DIV2_W  = 31;
    localparam int unsigned DIV2_RW = 32;
    localparam longint unsigned LAT_LIM = 64'd90 << LAT_FRAC_BITS;
    localparam int unsigned NTERM = egca_pkg::TAYLOR_TERMS;

    logic en;

    // ---------------- configuration ----------------
    logic        cfg_wr;
    logic [15:0] r_cell_size;
    logic [31:0] r_cell_sq;
    logic [31:0] n_cell_sq;

    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == egca_pkg::REG_CELL_SIZE);
    assign n_cell_sq = 32'(pwdata[15:0]) * 32'(pwdata[15:0]);

    // cell edge and its square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= egca_pkg::CELL_SIZE_RESET;
            r_cell_sq   <= 32'(egca_pkg::CELL_SIZE_RESET) * 32'(egca_pkg::CELL_SIZE_RESET);
        end else if (cfg_wr) begin
            r_cell_size <= pwdata[15:0];
            r_cell_sq   <= n_cell_sq;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == egca_pkg::REG_CELL_SIZE) ? {16'd0, r_cell_size} : 32'd0;

    // ---------------- front end ----------------
    logic [17:0] n_raw;
    logic [17:0] n_mag;
    logic [17:0] n_mag_c;
    logic [63:0] n_prod1;
    logic        r_f1_valid;
    logic [17:0] r_f1_mag;
    logic        r_f2_valid;
    logic [DIV1_W-1:0] r_f2_dvd;

    // magnitude, clamped to 90 degrees
    always_comb begin
        n_raw   = i_s_axis_tdata[17:0];
        n_mag   = n_raw[17] ? (18'd0 - n_raw) : n_raw;
        n_mag_c = (64'(n_mag) > LAT_LIM) ? 18'(LAT_LIM) : n_mag;
        n_prod1 = 64'(r_f1_mag) * egca_pkg::PI_Q30;
    end

    // front end valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid <= i_s_axis_tvalid;
            r_f2_valid <= r_f1_valid;
        end
    end

    // front end payload: angle numerator, pre-divided by 2^frac
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_mag <= n_mag_c;
            r_f2_dvd <= DIV1_W'(n_prod1 >> LAT_FRAC_BITS);
        end
    end

    // ---------------- division by 180 ----------------
    // long division in a HI_W-bit high digit and a 22-bit low digit, each by reciprocal product
    logic [63:0]     n_q1p;
    logic [HI_W-1:0] n_r1;
    logic [63:0]     n_q2p;
    logic            r_q_valid;
    logic [HI_W-1:0] r_q_q1;
    logic [HI_W-1:0] r_q_hi;
    logic [LO_W-1:0] r_q_lo;
    logic            r_r_valid;
    logic [HI_W-1:0] r_r_q1;
    logic [29:0]     r_r_v;
    logic            r_d_valid;
    logic [30:0]     r_d_x;

    always_comb begin
        n_q1p = 64'(r_f2_dvd[DIV1_W-1:LO_W]) * RECIP_180;
        n_r1  = r_q_hi - HI_W'(r_q_q1 * HI_W'(180));
        n_q2p = 64'(r_r_v) * RECIP_180;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_q_valid <= r_f2_valid;
            r_r_valid <= r_q_valid;
            r_d_valid <= r_r_valid;
        end
    end

    // high quotient digit, then remainder joined to the low digit, then low quotient
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_q1 <= HI_W'(n_q1p >> 38);
            r_q_hi <= r_f2_dvd[DIV1_W-1:LO_W];
            r_q_lo <= r_f2_dvd[LO_W-1:0];
            r_r_q1 <= r_q_q1;
            r_r_v  <= {n_r1[7:0], r_q_lo};
            r_d_x  <= 31'({r_r_q1, n_q2p[59:38]});
        end
    end

    // ---------------- x squared ----------------
    logic [63:0] n_xx;
    logic        r_x_valid;
    logic [31:0] r_x2;

    assign n_xx = 64'(r_d_x) * 64'(r_d_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (en) begin
            r_x_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x2 <= n_xx[61:30];
        end
    end

    // ---------------- cosine, horner chain from the highest term ----------------
    logic        h_valid [0:NTERM];
    logic [31:0] h_x2    [0:NTERM];
    logic [30:0] h_t     [0:NTERM];

    assign h_valid[0] = r_x_valid;
    assign h_x2[0]    = r_x2;
    assign h_t[0]     = 31'(egca_pkg::Q30_ONE);

    for (genvar gk = 0; gk < NTERM; gk++) begin : g_horner
        egca_horner_cell #(.TERM(NTERM - gk)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(h_valid[gk]),
            .i_x2   (h_x2[gk]),
            .i_t    (h_t[gk]),
            .o_valid(h_valid[gk+1]),
            .o_x2   (h_x2[gk+1]),
            .o_t    (h_t[gk+1])
        );
    end

    // ---------------- sin^2, w and w^2 ----------------
    logic [63:0] n_cc;
    logic [63:0] n_es;
    logic [63:0] n_ww;
    logic [2:0]  r_s_valid;
    logic [30:0] r_s1_c;
    logic [30:0] r_s1_s2;
    logic [30:0] r_s2_c;
    logic [30:0] r_s2_w;
    logic [30:0] r_s3_c;
    logic [30:0] r_s3_w2;

    always_comb begin
        n_cc = 64'(h_t[NTERM]) * 64'(h_t[NTERM]);
        n_es = egca_pkg::E2_Q30 * 64'(r_s1_s2);
        n_ww = 64'(r_s2_w) * 64'(r_s2_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= '0;
        end else if (en) begin
            r_s_valid <= {r_s_valid[1:0], h_valid[NTERM]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_c  <= h_t[NTERM];
            r_s1_s2 <= 31'(egca_pkg::Q30_ONE - (n_cc >> 30));
            r_s2_c  <= r_s1_c;
            r_s2_w  <= 31'(egca_pkg::Q30_ONE - (n_es >> 30));
            r_s3_c  <= r_s2_c;
            r_s3_w2 <= 31'(n_ww >> 30);
        end
    end

    // ---------------- division cos / w^2 ----------------
    logic               d2_valid [0:DIV2_W];
    logic [DIV2_RW-1:0] d2_rem   [0:DIV2_W];
    logic [DIV2_W-1:0]  d2_dq    [0:DIV2_W];
    logic [DIV2_RW-1:0] d2_div   [0:DIV2_W];

    // the top dividend bits (c >> 1) are already below w^2
    assign d2_valid[0] = r_s_valid[2];
    assign d2_rem[0]   = DIV2_RW'(r_s3_c >> 1);
    assign d2_dq[0]    = {r_s3_c[0], 30'd0};
    assign d2_div[0]   = DIV2_RW'(r_s3_w2);

    for (genvar gj = 0; gj < DIV2_W; gj++) begin : g_div2
        egca_div_cell #(.RW(DIV2_RW), .DW(DIV2_W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(d2_valid[gj]),
            .i_rem  (d2_rem[gj]),
            .i_dq   (d2_dq[gj]),
            .i_div  (d2_div[gj]),
            .o_valid(d2_valid[gj+1]),
            .o_rem  (d2_rem[gj+1]),
            .o_dq   (d2_dq[gj+1]),
            .o_div  (d2_div[gj+1])
        );
    end

    // ---------------- scale and cell size ----------------
    logic [63:0] n_pk;
    logic [63:0] n_area;
    logic        r_p_valid;
    logic [30:0] r_p;
    logic        r_a_valid;
    logic [39:0] r_a_area;

    always_comb begin
        n_pk   = egca_pkg::K_Q16 * 64'(d2_dq[DIV2_W]);
        n_area = 64'(r_p) * 64'(r_cell_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= d2_valid[DIV2_W];
            r_a_valid <= r_p_valid;
        end
    end

    // the product stays below 2^63, so the 40-bit area never saturates
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p      <= 31'(n_pk >> 30);
            r_a_area <= 40'(n_area >> 24);
        end
    end

    // ---------------- output register and skid ----------------
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_skid_valid;
    logic [39:0] r_skid_data;

    assign en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_a_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (r_a_valid) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_data <= r_a_area;
            end else begin
                r_skid_data <= r_a_area;
            end
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    `EGCA_ASSERT_IMPLY(a_skid_needs_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `EGCA_ASSERT_IMPLY(a_stall_only_when_full, !o_s_axis_tready, o_m_axis_tvalid, "input stalled with no result waiting")
    `EGCA_ASSERT_IMPLY(a_skid_on_stall, $rose(r_skid_valid), $past(r_out_valid && !i_m_axis_tready), "skid filled without output stall")
    `EGCA_ASSERT_NEXT(a_cell_sq, cfg_wr, r_cell_sq == 32'(r_cell_size) * 32'(r_cell_size), "cell size square out of step")

endmodule

`default_nettype wire

@@ rtl/egca_div_cell.sv @@
// one restoring division step: shifts in a dividend bit, yields one quotient bit
// depends on nothing but its parameters
`default_nettype none

module egca_div_cell #(
    parameter int unsigned RW = 9,
    parameter int unsigned DW = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [DW-1:0] i_dq,
    input  wire logic [RW-1:0] i_div,
    output logic               o_valid,
    output logic [RW-1:0]      o_rem,
    output logic [DW-1:0]      o_dq,
    output logic [RW-1:0]      o_div
);

    logic [RW-1:0] n_shift;
    logic          n_ge;
    logic [RW-1:0] n_rem;
    logic [DW-1:0] n_dq;
    logic          r_valid;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_dq;
    logic [RW-1:0] r_div;

    // trial subtract of the shifted remainder
    always_comb begin
        n_shift = {i_rem[RW-2:0], i_dq[DW-1]};
        n_ge    = (n_shift >= i_div);
        n_rem   = n_ge ? (n_shift - i_div) : n_shift;
        n_dq    = {i_dq[DW-2:0], n_ge};
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
            r_div <= i_div;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_div   = r_div;

endmodule

`default_nettype wire

@@ rtl/egca_horner_cell.sv @@
// one horner step of the cosine series: t' = 1 - (x2 * t) / (2k(2k-1)), in q30
// depends on egca_pkg; three register stages inside
`default_nettype none

module egca_horner_cell #(
    parameter int unsigned TERM = 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_x2,
    input  wire logic [30:0] i_t,
    output logic             o_valid,
    output logic [31:0]      o_x2,
    output logic [30:0]      o_t
);

    localparam longint unsigned DIVISOR = longint'(2 * TERM * (2 * TERM - 1));
    localparam longint unsigned RECIP   = (64'd1 << 32) / DIVISOR;

    logic [63:0] n_prod_a;
    logic [63:0] n_prod_b;
    logic [39:0] n_qd;
    logic [39:0] n_rr;
    logic [32:0] n_q;
    logic [30:0] n_t;

    logic [2:0]  r_valid;
    logic [31:0] r_a_x2;
    logic [31:0] r_a_v;
    logic [31:0] r_b_x2;
    logic [31:0] r_b_v;
    logic [31:0] r_b_qe;
    logic [31:0] r_c_x2;
    logic [30:0] r_c_t;

    // product, quotient estimate by reciprocal, then one-step correction
    always_comb begin
        n_prod_a = 64'(i_x2) * 64'(i_t);
        n_prod_b = 64'(r_a_v) * 64'(RECIP);
        n_qd     = 40'(r_b_qe) * 40'(DIVISOR);
        n_rr     = 40'(r_b_v) - n_qd;
        n_q      = 33'(r_b_qe) + 33'(n_rr >= 40'(DIVISOR));
        n_t      = (64'(n_q) >= egca_pkg::Q30_ONE) ? 31'd0
                                                   : 31'(egca_pkg::Q30_ONE - 64'(n_q));
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x2 <= i_x2;
            r_a_v  <= n_prod_a[61:30];
            r_b_x2 <= r_a_x2;
            r_b_v  <= r_a_v;
            r_b_qe <= n_prod_b[63:32];
            r_c_x2 <= r_b_x2;
            r_c_t  <= n_t;
        end
    end

    assign o_valid = r_valid[2];
    assign o_x2    = r_c_x2;
    assign o_t     = r_c_t;

endmodule

`default_nettype wire
